FILE: rtl/snfcs_pkg.sv
package snfcs_pkg;

    localparam int PAGE_SIZE    = 256;
    localparam int SECTOR_SIZE  = 4096;
    localparam int ADDRESS_BITS = 24;
    localparam int PAGE_BITS    = $clog2(PAGE_SIZE);
    localparam int SECTOR_BITS  = $clog2(SECTOR_SIZE);
    localparam int CHUNK_W      = PAGE_BITS + 1;

    localparam logic [3:0] OP_STATUS = 4'd0;
    localparam logic [3:0] OP_ID     = 4'd1;
    localparam logic [3:0] OP_READ   = 4'd2;
    localparam logic [3:0] OP_WRITE  = 4'd3;
    localparam logic [3:0] OP_SECTOR = 4'd4;
    localparam logic [3:0] OP_BLOCK  = 4'd5;
    localparam logic [3:0] OP_CHIP   = 4'd6;
    localparam logic [3:0] OP_RANGE  = 4'd7;
    localparam logic [3:0] OP_WBYTE  = 4'd8;
    localparam logic [3:0] OP_REPLY  = 4'd9;

    localparam logic [1:0] KIND_SPI  = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_REQ  = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [7:0] SPI_RDSR  = 8'h05;
    localparam logic [7:0] SPI_WREN  = 8'h06;
    localparam logic [7:0] SPI_RDID  = 8'h90;
    localparam logic [7:0] SPI_READ  = 8'h03;
    localparam logic [7:0] SPI_PROG  = 8'h02;
    localparam logic [7:0] SPI_SE    = 8'h20;
    localparam logic [7:0] SPI_BE    = 8'hD8;
    localparam logic [7:0] SPI_CE    = 8'hC7;
    localparam logic [7:0] SPI_DUMMY = 8'hFF;
    localparam logic [7:0] SPI_ZERO  = 8'h00;

    typedef enum logic [3:0] {
        PH_IDLE, PH_POLL_CMD, PH_POLL_DATA, PH_ID, PH_WREN,
        PH_HDR, PH_RDATA, PH_WAIT_WB, PH_WDATA
    } t_phase;

    typedef enum logic [2:0] {
        G_STATUS, G_PRE_READ, G_PRE_WREN, G_POST_WREN, G_POST_OP
    } t_goal;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [23:0] address;
        logic [24:0] length;
        logic [11:0] first_sector;
        logic [11:0] last_sector;
        logic [7:0]  data_byte;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  spi_byte;
        logic        release_select;
        logic [15:0] host_data;
        logic        ok;
        logic        last;
    } t_res;

    // Opcode class tagged by the front end.
    typedef enum logic [1:0] {
        C_CMD, C_WBYTE, C_REPLY, C_NONE
    } t_class;

    typedef struct packed {
        t_class cls;
        t_cmd   cmd;
    } t_qitem;

endpackage

FILE: rtl/snfcs_if.sv
interface snfcs_cmd_if;
    import snfcs_pkg::*;
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface snfcs_res_if;
    import snfcs_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/snfcs_front.sv
module snfcs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    snfcs_cmd_if.sink            i_cmd,
    output logic                 o_q_valid,
    output snfcs_pkg::t_qitem    o_q_item,
    input  logic                 i_q_pop
);
    import snfcs_pkg::*;

    // Two-entry queue that decouples intake from sequencing.
    t_qitem     r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_class     w_cls;
    logic       w_push;

    // Classify the opcode.
    always_comb begin
        unique case (i_cmd.data.opcode) inside
            [OP_STATUS:OP_RANGE]: w_cls = C_CMD;
            OP_WBYTE:             w_cls = C_WBYTE;
            OP_REPLY:             w_cls = C_REPLY;
            default:              w_cls = C_NONE;
        endcase
    end

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_item    = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ i_q_pop;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{cls: w_cls, cmd: i_cmd.data};
        end
    end

endmodule

FILE: rtl/snfcs_back.sv
module snfcs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  snfcs_pkg::t_qitem i_q_item,
    output logic              o_q_pop,
    snfcs_res_if.source       o_res
);
    import snfcs_pkg::*;

    localparam logic [ADDRESS_BITS-1:0] ONE_A = ADDRESS_BITS'(1);

    t_phase                  r_phase, n_phase;
    t_goal                   r_goal, n_goal;
    logic [2:0]              r_ck, n_ck;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [24:0]             r_left, n_left;
    logic [CHUNK_W-1:0]      r_chunk, n_chunk;
    logic [11:0]             r_sec, n_sec, r_send, n_send;
    logic [7:0]              r_idh, n_idh;
    logic [2:0]              r_bi, n_bi;

    // Results of the item being emitted: three slots, at most two used.
    t_res       r_buf [3];
    t_res       n_buf [3];
    logic [1:0] r_cnt, n_cnt, r_pos, n_pos;
    logic       w_busy, w_take, w_set_chunk;
    t_cmd       w_c;
    logic [7:0] w_b;
    logic [1:0] w_n;
    t_res       w_r [3];
    logic [PAGE_BITS:0]      w_room;

    assign w_busy  = (r_cnt != 2'd0);
    assign w_take  = i_q_valid && !w_busy;
    assign o_q_pop = w_take;
    assign w_c     = i_q_item.cmd;
    assign w_b     = w_c.data_byte;
    assign o_res.valid = w_busy;
    assign o_res.data  = r_buf[r_pos];

    function automatic t_res mk(input logic [1:0] k, input logic [7:0] sb, input logic rel,
                                input logic [15:0] hd, input logic ok);
        t_res r;
        r.kind = k; r.spi_byte = sb; r.release_select = rel;
        r.host_data = hd; r.ok = ok; r.last = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] hdr_op(input logic [2:0] k);
        logic [7:0] v;
        case (k)
            OP_READ[2:0]:                 v = SPI_READ;
            OP_WRITE[2:0]:                v = SPI_PROG;
            OP_BLOCK[2:0]:                v = SPI_BE;
            OP_CHIP[2:0]:                 v = SPI_CE;
            OP_SECTOR[2:0], OP_RANGE[2:0]: v = SPI_SE;
            default:                      v = SPI_ZERO;
        endcase
        return v;
    endfunction

    // Sequencer step: next phase and the results caused by one queued item.
    always_comb begin
        n_phase = r_phase; n_goal = r_goal; n_ck = r_ck; n_addr = r_addr;
        n_left = r_left; n_chunk = r_chunk; n_sec = r_sec; n_send = r_send;
        n_idh = r_idh; n_bi = r_bi; w_n = 2'd0; w_set_chunk = 1'b0;
        for (int k = 0; k < 3; k++) w_r[k] = mk(KIND_SPI, 8'd0, 1'b0, 16'd0, 1'b0);
        unique case (i_q_item.cls)
            C_CMD: if (r_phase == PH_IDLE) begin
                n_ck = w_c.opcode[2:0];
                w_n  = 2'd1;
                w_r[0] = mk(KIND_SPI, SPI_RDSR, 1'b0, 16'd0, 1'b0);
                n_phase = PH_POLL_CMD;
                n_goal  = G_PRE_WREN;
                unique case (w_c.opcode)
                    OP_STATUS: n_goal = G_STATUS;
                    OP_ID: begin
                        n_bi = 3'd0;
                        w_r[0] = mk(KIND_SPI, SPI_RDID, 1'b0, 16'd0, 1'b0);
                        n_phase = PH_ID;
                    end
                    OP_READ, OP_WRITE: begin
                        if (w_c.length == 25'd0) begin
                            w_r[0] = mk(KIND_DONE, 8'd0, 1'b0, 16'd0, 1'b0);
                            n_phase = PH_IDLE;
                        end else begin
                            n_left = w_c.length;
                            n_addr = w_c.address[ADDRESS_BITS-1:0];
                            if (w_c.opcode == OP_READ) n_goal = G_PRE_READ;
                            else w_set_chunk = 1'b1;
                        end
                    end
                    OP_SECTOR, OP_BLOCK, OP_CHIP: n_addr = w_c.address[ADDRESS_BITS-1:0];
                    default: begin
                        if (w_c.first_sector > w_c.last_sector) begin
                            w_r[0] = mk(KIND_DONE, 8'd0, 1'b0, 16'd0, 1'b1);
                            n_phase = PH_IDLE;
                        end else begin
                            n_sec  = w_c.first_sector;
                            n_send = w_c.last_sector;
                            n_addr = ADDRESS_BITS'({w_c.first_sector, {SECTOR_BITS{1'b0}}});
                        end
                    end
                endcase
            end
            C_WBYTE: if (r_phase == PH_WAIT_WB) begin
                w_n = 2'd1;
                w_r[0] = mk(KIND_SPI, w_b, r_chunk == CHUNK_W'(1), 16'd0, 1'b0);
                n_phase = PH_WDATA;
            end
            C_REPLY: begin
                unique case (r_phase)
                    PH_POLL_CMD: begin
                        w_n = 2'd1;
                        w_r[0] = mk(KIND_SPI, SPI_DUMMY, 1'b1, 16'd0, 1'b0);
                        n_phase = PH_POLL_DATA;
                    end
                    PH_POLL_DATA: begin
                        w_n = 2'd1;
                        w_r[0] = mk(KIND_SPI, SPI_RDSR, 1'b0, 16'd0, 1'b0);
                        n_phase = PH_POLL_CMD;
                        if (r_goal == G_STATUS) begin
                            w_n = 2'd2;
                            w_r[0] = mk(KIND_HOST, 8'd0, 1'b0, {8'd0, w_b}, 1'b0);
                            w_r[1] = mk(KIND_DONE, 8'd0, 1'b0, 16'd0, 1'b1);
                            n_phase = PH_IDLE;
                        end else if (r_goal == G_POST_WREN) begin
                            if (w_b[1:0] == 2'b10) begin
                                w_r[0] = mk(KIND_SPI, hdr_op(r_ck), r_ck == OP_CHIP[2:0],
                                            16'd0, 1'b0);
                                n_bi = 3'd0; n_phase = PH_HDR;
                            end
                        end else if (w_b[0]) begin
                            // Still busy: poll again with the same goal.
                        end else if (r_goal == G_PRE_READ) begin
                            w_r[0] = mk(KIND_SPI, hdr_op(r_ck), 1'b0, 16'd0, 1'b0);
                            n_bi = 3'd0; n_phase = PH_HDR;
                        end else if (r_goal == G_PRE_WREN) begin
                            w_r[0] = mk(KIND_SPI, SPI_WREN, 1'b1, 16'd0, 1'b0);
                            n_phase = PH_WREN;
                        end else if (r_ck == OP_WRITE[2:0] && r_left != 25'd0) begin
                            w_set_chunk = 1'b1; n_goal = G_PRE_WREN;
                        end else if (r_ck == OP_RANGE[2:0] && r_sec != r_send) begin
                            n_sec  = r_sec + 12'd1;
                            n_addr = ADDRESS_BITS'({n_sec, {SECTOR_BITS{1'b0}}});
                            n_goal = G_PRE_WREN;
                        end else begin
                            w_r[0] = mk(KIND_DONE, 8'd0, 1'b0, 16'd0, 1'b1);
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_WREN: begin
                        w_n = 2'd1;
                        w_r[0] = mk(KIND_SPI, SPI_RDSR, 1'b0, 16'd0, 1'b0);
                        n_goal = G_POST_WREN; n_phase = PH_POLL_CMD;
                    end
                    PH_ID: begin
                        w_n = 2'd1;
                        n_bi = r_bi + 3'd1;
                        if (r_bi < 3'd3) begin
                            w_r[0] = mk(KIND_SPI, SPI_ZERO, 1'b0, 16'd0, 1'b0);
                        end else if (r_bi == 3'd3) begin
                            w_r[0] = mk(KIND_SPI, SPI_DUMMY, 1'b0, 16'd0, 1'b0);
                        end else if (r_bi == 3'd4) begin
                            n_idh = w_b;
                            w_r[0] = mk(KIND_SPI, SPI_DUMMY, 1'b1, 16'd0, 1'b0);
                        end else begin
                            w_n = 2'd2; n_bi = r_bi;
                            w_r[0] = mk(KIND_HOST, 8'd0, 1'b0, {r_idh, w_b}, 1'b0);
                            w_r[1] = mk(KIND_DONE, 8'd0, 1'b0, 16'd0, 1'b1);
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_HDR: begin
                        w_n = 2'd1;
                        if (r_ck == OP_CHIP[2:0] || (r_bi == 3'd3 &&
                            r_ck != OP_READ[2:0] && r_ck != OP_WRITE[2:0]))
                        begin
                            w_r[0] = mk(KIND_SPI, SPI_RDSR, 1'b0, 16'd0, 1'b0);
                            n_goal = G_POST_OP; n_phase = PH_POLL_CMD;
                        end else if (r_bi < 3'd3) begin
                            w_r[0] = mk(KIND_SPI,
                                8'(24'(r_addr) >> (5'd16 - {r_bi[1:0], 3'b000})),
                                r_bi == 3'd2 && r_ck >= OP_SECTOR[2:0], 16'd0, 1'b0);
                            n_bi = r_bi + 3'd1;
                        end else if (r_ck == OP_READ[2:0]) begin
                            w_r[0] = mk(KIND_SPI, SPI_DUMMY, r_left == 25'd1, 16'd0, 1'b0);
                            n_phase = PH_RDATA;
                        end else begin
                            w_r[0] = mk(KIND_REQ, 8'd0, 1'b0, 16'd0, 1'b0);
                            n_phase = PH_WAIT_WB;
                        end
                    end
                    PH_RDATA: begin
                        w_n = 2'd2;
                        n_left = r_left - 25'd1;
                        w_r[0] = mk(KIND_HOST, 8'd0, 1'b0, {8'd0, w_b}, 1'b0);
                        if (n_left == 25'd0) begin
                            w_r[1] = mk(KIND_DONE, 8'd0, 1'b0, 16'd0, 1'b1);
                            n_phase = PH_IDLE;
                        end else begin
                            w_r[1] = mk(KIND_SPI, SPI_DUMMY, n_left == 25'd1, 16'd0, 1'b0);
                        end
                    end
                    PH_WDATA: begin
                        w_n = 2'd1;
                        n_chunk = (r_chunk != '0) ? r_chunk - CHUNK_W'(1) : r_chunk;
                        n_left  = (r_left != '0) ? r_left - 25'd1 : r_left;
                        n_addr  = r_addr + ONE_A;
                        if (n_chunk == '0) begin
                            w_r[0] = mk(KIND_SPI, SPI_RDSR, 1'b0, 16'd0, 1'b0);
                            n_goal = G_POST_OP; n_phase = PH_POLL_CMD;
                        end else begin
                            w_r[0] = mk(KIND_REQ, 8'd0, 1'b0, 16'd0, 1'b0);
                            n_phase = PH_WAIT_WB;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        // Page-limited chunk for the next program operation.
        w_room = (PAGE_BITS+1)'(PAGE_SIZE) - {1'b0, n_addr[PAGE_BITS-1:0]};
        if (w_set_chunk) begin
            n_chunk = (n_left < 25'(w_room)) ? CHUNK_W'(n_left) : CHUNK_W'(w_room);
        end
        if (w_n != 2'd0) w_r[w_n - 2'd1].last = 1'b1;
    end

    // Output buffer drains one transaction per accepted handshake.
    always_comb begin
        n_cnt = r_cnt; n_pos = r_pos;
        for (int k = 0; k < 3; k++) n_buf[k] = r_buf[k];
        if (w_busy && o_res.ready) begin
            n_cnt = r_cnt - 2'd1;
            n_pos = r_pos + 2'd1;
        end
        if (w_take) begin
            n_cnt = w_n; n_pos = 2'd0;
            for (int k = 0; k < 3; k++) n_buf[k] = w_r[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_goal <= G_STATUS; r_ck <= '0; r_addr <= '0;
            r_left <= '0; r_chunk <= '0; r_sec <= '0; r_send <= '0;
            r_idh <= '0; r_bi <= '0; r_cnt <= '0; r_pos <= '0;
        end else begin
            r_cnt <= n_cnt; r_pos <= n_pos;
            if (w_take) begin
                r_phase <= n_phase; r_goal <= n_goal; r_ck <= n_ck; r_addr <= n_addr;
                r_left <= n_left; r_chunk <= n_chunk; r_sec <= n_sec;
                r_send <= n_send; r_idh <= n_idh; r_bi <= n_bi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) r_buf[k] <= n_buf[k];
    end

endmodule

FILE: rtl/spi_nor_flash_command_sequencer_top.sv
// SPI NOR flash command sequencer.
// The command channel carries host commands, write data bytes and the MISO
// byte that answers each SPI byte sent. The result channel carries SPI bytes
// to send, host data, write byte requests and command completions; the last
// result that an item causes is marked by its last flag.
// A command transaction is taken into a two-entry queue at once; the sequencer
// pulls one item from it when its result buffer is empty and emits the zero to
// two results of that item, one per cycle while the result channel is ready.
// An item passes through its queue entry and then the result buffer; its first
// result appears in the cycle after it leaves the queue. The next item is taken
// only once the result buffer has drained.
// Items that mean nothing in the current phase cause no result.
// A stalled result channel holds the buffer; the queue keeps accepting until
// its two entries are full, then drops ready.
// Reset is synchronous and active low; it returns the sequencer to idle.
module spi_nor_flash_command_sequencer_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    snfcs_cmd_if.sink   i_cmd,
    snfcs_res_if.source o_res
);
    import snfcs_pkg::*;

    logic   w_q_valid, w_q_pop;
    t_qitem w_q_item;

    snfcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .o_q_valid(w_q_valid),
        .o_q_item (w_q_item),
        .i_q_pop  (w_q_pop)
    );

    snfcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_q_item (w_q_item),
        .o_q_pop  (w_q_pop),
        .o_res    (o_res)
    );

endmodule

FILE: sim/spi_nor_flash_command_sequencer_top_tb.sv
`timescale 1ns / 100ps

module spi_nor_flash_command_sequencer_top_tb;
    import snfcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    snfcs_cmd_if cmd_if ();
    snfcs_res_if res_if ();

    spi_nor_flash_command_sequencer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Transactions waiting for the driver and results the sequencer owes.
    t_cmd pending_cmds[$];
    t_res expected_results[$];
    t_res step_results[$];
    int   errors;
    int   results_seen;
    bit   bursty;

    // Shadow copy of the sequencer state.
    t_phase      seq_phase;
    t_goal       seq_goal;
    logic [2:0]  seq_kind;
    logic [23:0] seq_addr;
    logic [24:0] seq_left;
    logic [8:0]  seq_chunk;
    logic [11:0] seq_sector;
    logic [11:0] seq_sector_end;
    logic [7:0]  seq_id_high;
    int          seq_index;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void emit(logic [1:0] k, logic [7:0] sb, logic rel, logic [15:0] hd,
                                 logic okv);
        t_res r;
        if (step_results.size() < 3) begin
            r.kind = k;
            r.spi_byte = sb;
            r.release_select = rel;
            r.host_data = hd;
            r.ok = okv;
            r.last = 1'b0;
            step_results.push_back(r);
        end
    endfunction

    function automatic void send_spi(logic [7:0] b, logic rel);
        emit(KIND_SPI, b, rel, 16'd0, 1'b0);
    endfunction

    function automatic void finish_cmd(logic okv);
        emit(KIND_DONE, 8'd0, 1'b0, 16'd0, okv);
        seq_phase = PH_IDLE;
    endfunction

    function automatic void start_poll(t_goal g);
        seq_goal = g;
        send_spi(SPI_RDSR, 1'b0);
        seq_phase = PH_POLL_CMD;
    endfunction

    // A program chunk never crosses a page boundary.
    function automatic void set_chunk();
        int room;
        room = PAGE_SIZE - (seq_addr % PAGE_SIZE);
        seq_chunk = (seq_left < room) ? seq_left[8:0] : room[8:0];
    endfunction

    function automatic void begin_header();
        logic [7:0] op;
        case (seq_kind)
            OP_READ[2:0]:  op = SPI_READ;
            OP_WRITE[2:0]: op = SPI_PROG;
            OP_BLOCK[2:0]: op = SPI_BE;
            OP_CHIP[2:0]:  op = SPI_CE;
            default:       op = SPI_SE;
        endcase
        seq_index = 0;
        send_spi(op, seq_kind == OP_CHIP[2:0]);
        seq_phase = PH_HDR;
    endfunction

    function automatic void finish_op();
        if (seq_kind == OP_WRITE[2:0] && seq_left != 0) begin
            set_chunk();
            start_poll(G_PRE_WREN);
        end else if (seq_kind == OP_RANGE[2:0] && seq_sector != seq_sector_end) begin
            seq_sector = seq_sector + 12'd1;
            seq_addr = 24'(seq_sector * SECTOR_SIZE);
            start_poll(G_PRE_WREN);
        end else begin
            finish_cmd(1'b1);
        end
    endfunction

    function automatic void take_reply(logic [7:0] b);
        case (seq_phase)
            PH_POLL_CMD: begin
                send_spi(SPI_DUMMY, 1'b1);
                seq_phase = PH_POLL_DATA;
            end
            PH_POLL_DATA: begin
                if (seq_goal == G_STATUS) begin
                    emit(KIND_HOST, 8'd0, 1'b0, {8'd0, b}, 1'b0);
                    finish_cmd(1'b1);
                end else if (seq_goal == G_POST_WREN) begin
                    if (b[1:0] != 2'b10) start_poll(G_POST_WREN);
                    else begin_header();
                end else if (b[0]) begin
                    start_poll(seq_goal);
                end else if (seq_goal == G_PRE_READ) begin
                    begin_header();
                end else if (seq_goal == G_PRE_WREN) begin
                    send_spi(SPI_WREN, 1'b1);
                    seq_phase = PH_WREN;
                end else begin
                    finish_op();
                end
            end
            PH_WREN: start_poll(G_POST_WREN);
            PH_ID: begin
                if (seq_index < 3) begin
                    send_spi(SPI_ZERO, 1'b0);
                end else if (seq_index == 3) begin
                    send_spi(SPI_DUMMY, 1'b0);
                end else if (seq_index == 4) begin
                    seq_id_high = b;
                    send_spi(SPI_DUMMY, 1'b1);
                end else begin
                    emit(KIND_HOST, 8'd0, 1'b0, {seq_id_high, b}, 1'b0);
                    finish_cmd(1'b1);
                end
                if (seq_phase == PH_ID) seq_index++;
            end
            PH_HDR: begin
                if (seq_kind == OP_CHIP[2:0]) begin
                    start_poll(G_POST_OP);
                end else if (seq_index < 3) begin
                    send_spi(seq_addr[23 - 8 * seq_index -: 8],
                             seq_index == 2 && seq_kind >= OP_SECTOR[2:0]);
                    seq_index++;
                end else if (seq_kind == OP_READ[2:0]) begin
                    send_spi(SPI_DUMMY, seq_left == 1);
                    seq_phase = PH_RDATA;
                end else if (seq_kind == OP_WRITE[2:0]) begin
                    emit(KIND_REQ, 8'd0, 1'b0, 16'd0, 1'b0);
                    seq_phase = PH_WAIT_WB;
                end else begin
                    start_poll(G_POST_OP);
                end
            end
            PH_RDATA: begin
                emit(KIND_HOST, 8'd0, 1'b0, {8'd0, b}, 1'b0);
                seq_left = seq_left - 25'd1;
                if (seq_left == 0) finish_cmd(1'b1);
                else send_spi(SPI_DUMMY, seq_left == 1);
            end
            PH_WDATA: begin
                if (seq_chunk != 0) seq_chunk = seq_chunk - 9'd1;
                if (seq_left != 0) seq_left = seq_left - 25'd1;
                seq_addr = seq_addr + 24'd1;
                if (seq_chunk == 0) begin
                    start_poll(G_POST_OP);
                end else begin
                    emit(KIND_REQ, 8'd0, 1'b0, 16'd0, 1'b0);
                    seq_phase = PH_WAIT_WB;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void take_command(t_cmd c);
        seq_kind = c.opcode[2:0];
        case (c.opcode)
            OP_STATUS: start_poll(G_STATUS);
            OP_ID: begin
                seq_index = 0;
                send_spi(SPI_RDID, 1'b0);
                seq_phase = PH_ID;
            end
            OP_READ, OP_WRITE: begin
                if (c.length == 0) begin
                    finish_cmd(1'b0);
                end else begin
                    seq_left = c.length;
                    seq_addr = c.address;
                    if (c.opcode == OP_READ) begin
                        start_poll(G_PRE_READ);
                    end else begin
                        set_chunk();
                        start_poll(G_PRE_WREN);
                    end
                end
            end
            OP_SECTOR, OP_BLOCK, OP_CHIP: begin
                seq_addr = c.address;
                start_poll(G_PRE_WREN);
            end
            default: begin
                if (c.first_sector > c.last_sector) begin
                    finish_cmd(1'b1);
                end else begin
                    seq_sector = c.first_sector;
                    seq_sector_end = c.last_sector;
                    seq_addr = 24'(c.first_sector * SECTOR_SIZE);
                    start_poll(G_PRE_WREN);
                end
            end
        endcase
    endfunction

    // Predicts the results of one transaction, queues them and the item.
    // Returns the number of results it causes.
    function automatic int sequence_item(t_cmd c);
        int n;
        step_results.delete();
        if (c.opcode <= OP_RANGE) begin
            if (seq_phase == PH_IDLE) take_command(c);
        end else if (c.opcode == OP_WBYTE) begin
            if (seq_phase == PH_WAIT_WB) begin
                send_spi(c.data_byte, seq_chunk == 1);
                seq_phase = PH_WDATA;
            end
        end else if (c.opcode == OP_REPLY) begin
            if (seq_phase != PH_IDLE && seq_phase != PH_WAIT_WB) take_reply(c.data_byte);
        end
        n = step_results.size();
        if (n > 0) step_results[n - 1].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
        pending_cmds.push_back(c);
        return n;
    endfunction

    function automatic t_cmd random_cmd(logic [3:0] op);
        t_cmd c;
        c.opcode = op;
        c.address = 24'($urandom);
        c.length = 25'($urandom);
        c.first_sector = 12'($urandom);
        c.last_sector = 12'($urandom);
        c.data_byte = 8'($urandom);
        return c;
    endfunction

    // Answers the sequencer the way a flash part would, busy now and then.
    function automatic t_cmd flash_answer();
        t_cmd c;
        if (seq_phase == PH_WAIT_WB) return random_cmd(OP_WBYTE);
        c = random_cmd(OP_REPLY);
        if (seq_phase == PH_POLL_DATA) begin
            if (seq_goal == G_POST_WREN) begin
                if ($urandom_range(0, 3) != 0) c.data_byte[1:0] = 2'b10;
            end else begin
                c.data_byte[0] = ($urandom_range(0, 3) == 0);
            end
        end
        return c;
    endfunction

    // Drives a command and then answers until the sequencer is idle again,
    // mixing in, when with_noise is set, stray transactions that must be ignored or handled.
    // Returns the number of transactions queued.
    function automatic int run_command(t_cmd c, bit with_noise);
        int n;
        t_cmd stray;
        logic [3:0] op;
        void'(sequence_item(c));
        n = 1;
        while (seq_phase != PH_IDLE) begin
            if (with_noise && $urandom_range(0, 9) == 0) begin
                op = 4'($urandom_range(0, 14));
                if (op >= OP_REPLY) op = op + 4'd1;
                stray = random_cmd(op);
                void'(sequence_item(stray));
                n++;
            end
            void'(sequence_item(flash_answer()));
            n++;
        end
        return n;
    endfunction

    function automatic t_cmd make_cmd(logic [3:0] op, logic [23:0] a, logic [24:0] len,
                                      logic [11:0] fs, logic [11:0] ls);
        t_cmd c;
        c = random_cmd(op);
        c.address = a;
        c.length = len;
        c.first_sector = fs;
        c.last_sector = ls;
        return c;
    endfunction

    // Stimulus: directed commands first, then random command sequences.
    initial begin
        int items;
        t_cmd c;
        errors = 0;
        bursty = 1'b0;
        seq_phase = PH_IDLE;
        seq_goal = G_STATUS;
        seq_kind = '0;
        seq_addr = '0;
        seq_left = '0;
        seq_chunk = '0;
        seq_sector = '0;
        seq_sector_end = '0;
        seq_id_high = '0;
        seq_index = 0;
        items = 0;

        // Stray transactions while idle.
        void'(sequence_item(random_cmd(4'd12)));
        void'(sequence_item(random_cmd(4'd15)));
        void'(sequence_item(random_cmd(OP_REPLY)));
        void'(sequence_item(random_cmd(OP_WBYTE)));
        items += 4;
        items += run_command(make_cmd(OP_STATUS, 24'h0, 25'h0, 12'h0, 12'h0), 1'b0);
        items += run_command(make_cmd(OP_ID, 24'h0, 25'h0, 12'h0, 12'h0), 1'b0);
        items += run_command(make_cmd(OP_READ, 24'h0, 25'h0, 12'h0, 12'h0), 1'b0);
        items += run_command(make_cmd(OP_WRITE, 24'hFFFFFF, 25'h0, 12'h0, 12'h0), 1'b0);
        items += run_command(make_cmd(OP_READ, 24'h000000, 25'd1, 12'h0, 12'h0), 1'b0);
        items += run_command(make_cmd(OP_READ, 24'hFFFFFF, 25'd3, 12'h0, 12'h0), 1'b0);
        // Write that crosses a page boundary and one that wraps the address.
        items += run_command(make_cmd(OP_WRITE, 24'h0000FC, 25'd6, 12'h0, 12'h0), 1'b0);
        items += run_command(make_cmd(OP_WRITE, 24'hFFFFFE, 25'd3, 12'h0, 12'h0), 1'b0);
        items += run_command(make_cmd(OP_SECTOR, 24'hFFFFFF, 25'h0, 12'h0, 12'h0), 1'b0);
        items += run_command(make_cmd(OP_BLOCK, 24'h000000, 25'h0, 12'h0, 12'h0), 1'b0);
        items += run_command(make_cmd(OP_CHIP, 24'h5A5A5A, 25'h0, 12'h0, 12'h0), 1'b0);
        // Empty range, then ranges at both ends of the sector space.
        items += run_command(make_cmd(OP_RANGE, 24'h0, 25'h0, 12'd5, 12'd4), 1'b0);
        items += run_command(make_cmd(OP_RANGE, 24'h0, 25'h0, 12'd0, 12'd1), 1'b0);
        items += run_command(make_cmd(OP_RANGE, 24'h0, 25'h0, 12'hFFF, 12'hFFF), 1'b0);

        while (items < 500) begin
            c = random_cmd(4'($urandom_range(0, 7)));
            case ($urandom_range(0, 3))
                0: c.address[7:0] = 8'($urandom_range(240, 255));
                1: c.address = 24'hFFFFFF - 24'($urandom_range(0, 8));
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0: c.length = 25'd0;
                1: c.length = 25'($urandom_range(7, 40));
                default: c.length = 25'($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 5) != 0)
                c.last_sector = (c.first_sector > 12'd4093) ? 12'hFFF
                                : c.first_sector + 12'($urandom_range(0, 2));
            items += run_command(c, 1'b1);
        end

        while (pending_cmds.size() != 0 || cmd_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Reset.
    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Command driver: each item draws its own gap, with idle-free bursts.
    int gap_left;
    int driven;
    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        res_if.ready = 1'b0;
        gap_left = 0;
        driven = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                cmd_if.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cmd_if.data <= pending_cmds.pop_front();
                cmd_if.valid <= 1'b1;
                driven <= driven + 1;
                if (driven % 64 == 0) bursty <= ~bursty;
                gap_left <= bursty ? 0 : $urandom_range(0, 3);
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each transaction and stalls at random.
    int stall_left;
    bit held_off;
    initial begin
        stall_left = 0;
        held_off = 1'b0;
        results_seen = 0;
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        int next_stall;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            next_stall = (stall_left > 0) ? stall_left - 1 : 0;
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind || got.spi_byte != want.spi_byte ||
                        got.release_select != want.release_select ||
                        got.host_data != want.host_data || got.ok != want.ok ||
                        got.last != want.last) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
                // One long hold-off so the input queue fills and stalls.
                if (!held_off && results_seen >= 150) begin
                    held_off <= 1'b1;
                    next_stall = HOLD_OFF_CYCLES;
                end else begin
                    next_stall = bursty ? 0 : $urandom_range(0, 3);
                end
            end
            stall_left <= next_stall;
            res_if.ready <= (next_stall == 0);
        end
    end

    // Watchdog on cycles without any accepted transaction.
    int quiet_cycles;
    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
